// ===== design/mer_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, codes and constants of the midpoint ellipse rasterizer.
package mer_pkg;

	localparam int AXIS_BITS_DEF = 10;
	localparam int CENTER_W      = 12;
	localparam int SEMI_W        = 10;
	localparam int POINT_W       = 13;

	localparam logic       KIND_START = 1'b0;
	localparam logic [1:0] LAST_PIX   = 2'd3;

	typedef enum logic [1:0] {
		PH_DONE = 2'd0,
		PH_R1   = 2'd1,
		PH_R2   = 2'd2
	} phase_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SQ_AB,
		ST_INIT_MUL,
		ST_INIT_SET,
		ST_CHK_SQ,
		ST_CHK_MUL,
		ST_CHK_EVAL,
		ST_STEP_MUL,
		ST_EMIT,
		ST_DONE_OUT
	} state_t;

	typedef enum logic [3:0] {
		OP_NONE,
		OP_LATCH,
		OP_SQ_AB,
		OP_INIT_MUL,
		OP_INIT_SET,
		OP_CHK_SQ,
		OP_CHK_MUL,
		OP_CHK_EVAL,
		OP_STEP_MUL,
		OP_EMIT,
		OP_EMIT_DONE
	} op_t;

	typedef struct packed {
		op_t        op;
		logic [1:0] pix_idx;
	} dp_cmd_t;

	typedef struct packed {
		phase_t phase;
		logic   in_region;
		logic   out_free;
	} dp_sts_t;

endpackage

// ===== design/mer_cmd_if.sv =====
`timescale 1ns / 1ps
// Input channel: start and step words with valid/ready handshake.
interface mer_cmd_if;
	logic                                valid;
	logic                                ready;
	logic                                kind;
	logic signed [mer_pkg::CENTER_W-1:0] center_x;
	logic signed [mer_pkg::CENTER_W-1:0] center_y;
	logic [mer_pkg::SEMI_W-1:0]          semi_a;
	logic [mer_pkg::SEMI_W-1:0]          semi_b;

	modport source (output valid, kind, center_x, center_y, semi_a, semi_b, input ready);
	modport sink (input valid, kind, center_x, center_y, semi_a, semi_b, output ready);
endinterface

// ===== design/mer_pix_if.sv =====
`timescale 1ns / 1ps
// Output channel: pixel words with valid/ready handshake.
interface mer_pix_if;
	logic                               valid;
	logic                               ready;
	logic signed [mer_pkg::POINT_W-1:0] point_x;
	logic signed [mer_pkg::POINT_W-1:0] point_y;
	logic                               last;
	logic                               done_res;

	modport source (output valid, point_x, point_y, last, done_res, input ready);
	modport sink (input valid, point_x, point_y, last, done_res, output ready);
endinterface

// ===== design/mer_ctrl.sv =====
`timescale 1ns / 1ps
// Sequencer for setup, region check, step update and pixel emission.
module mer_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	input  logic              req_kind,
	output logic              req_ready,
	input  mer_pkg::dp_sts_t  sts,
	output mer_pkg::dp_cmd_t  cmd
);

	mer_pkg::state_t state_q;
	mer_pkg::state_t state_d;
	logic [1:0]      idx_q;
	logic            active;

	assign active = (sts.phase == mer_pkg::PH_R1) || (sts.phase == mer_pkg::PH_R2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mer_pkg::ST_IDLE;
			idx_q   <= '0;
		end else begin
			state_q <= state_d;
			if (cmd.op == mer_pkg::OP_EMIT) begin
				idx_q <= idx_q + 2'd1;
			end
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			mer_pkg::ST_IDLE: begin
				if (req_valid) begin
					if (req_kind == mer_pkg::KIND_START) begin
						state_d = mer_pkg::ST_SQ_AB;
					end else if (active) begin
						state_d = mer_pkg::ST_CHK_SQ;
					end else begin
						state_d = mer_pkg::ST_DONE_OUT;
					end
				end
			end
			mer_pkg::ST_SQ_AB:    state_d = mer_pkg::ST_INIT_MUL;
			mer_pkg::ST_INIT_MUL: state_d = mer_pkg::ST_INIT_SET;
			mer_pkg::ST_INIT_SET: state_d = mer_pkg::ST_IDLE;
			mer_pkg::ST_CHK_SQ:   state_d = mer_pkg::ST_CHK_MUL;
			mer_pkg::ST_CHK_MUL:  state_d = mer_pkg::ST_CHK_EVAL;
			mer_pkg::ST_CHK_EVAL: begin
				if (sts.in_region) begin
					state_d = mer_pkg::ST_STEP_MUL;
				end else if (sts.phase == mer_pkg::PH_R1) begin
					// region 2 gets loaded now; check it from the top
					state_d = mer_pkg::ST_CHK_SQ;
				end else begin
					state_d = mer_pkg::ST_DONE_OUT;
				end
			end
			mer_pkg::ST_STEP_MUL: state_d = mer_pkg::ST_EMIT;
			mer_pkg::ST_EMIT: begin
				if (sts.out_free && idx_q == mer_pkg::LAST_PIX) begin
					state_d = mer_pkg::ST_IDLE;
				end
			end
			mer_pkg::ST_DONE_OUT: begin
				if (sts.out_free) begin
					state_d = mer_pkg::ST_IDLE;
				end
			end
			default: state_d = mer_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		req_ready   = 1'b0;
		cmd.op      = mer_pkg::OP_NONE;
		cmd.pix_idx = idx_q;
		case (state_q)
			mer_pkg::ST_IDLE: begin
				req_ready = 1'b1;
				if (req_valid && req_kind == mer_pkg::KIND_START) begin
					cmd.op = mer_pkg::OP_LATCH;
				end
			end
			mer_pkg::ST_SQ_AB:    cmd.op = mer_pkg::OP_SQ_AB;
			mer_pkg::ST_INIT_MUL: cmd.op = mer_pkg::OP_INIT_MUL;
			mer_pkg::ST_INIT_SET: cmd.op = mer_pkg::OP_INIT_SET;
			mer_pkg::ST_CHK_SQ:   cmd.op = mer_pkg::OP_CHK_SQ;
			mer_pkg::ST_CHK_MUL:  cmd.op = mer_pkg::OP_CHK_MUL;
			mer_pkg::ST_CHK_EVAL: cmd.op = mer_pkg::OP_CHK_EVAL;
			mer_pkg::ST_STEP_MUL: cmd.op = mer_pkg::OP_STEP_MUL;
			mer_pkg::ST_EMIT: begin
				if (sts.out_free) begin
					cmd.op = mer_pkg::OP_EMIT;
				end
			end
			mer_pkg::ST_DONE_OUT: begin
				if (sts.out_free) begin
					cmd.op = mer_pkg::OP_EMIT_DONE;
				end
			end
			default: cmd.op = mer_pkg::OP_NONE;
		endcase
	end

endmodule

// ===== design/mer_dp.sv =====
`timescale 1ns / 1ps
// Datapath: operand registers, multipliers, decision term and output register.
module mer_dp #(
	parameter int AXIS_BITS = mer_pkg::AXIS_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  mer_pkg::dp_cmd_t                    ctl,
	output mer_pkg::dp_sts_t                    sts,
	input  logic signed [mer_pkg::CENTER_W-1:0] center_x,
	input  logic signed [mer_pkg::CENTER_W-1:0] center_y,
	input  logic [mer_pkg::SEMI_W-1:0]          semi_a,
	input  logic [mer_pkg::SEMI_W-1:0]          semi_b,
	output logic                                pix_valid,
	input  logic                                pix_ready,
	output logic signed [mer_pkg::POINT_W-1:0]  point_x,
	output logic signed [mer_pkg::POINT_W-1:0]  point_y,
	output logic                                last,
	output logic                                done_res
);

	localparam int CUR_W  = AXIS_BITS + 1;
	localparam int DEC_W  = 4 * AXIS_BITS - 4;
	localparam int SQ_W   = 2 * AXIS_BITS;
	localparam int SUM_W  = 2 * AXIS_BITS + 1;
	localparam int LIM_W  = 4 * AXIS_BITS;
	localparam int NSQ_W  = 2 * CUR_W;
	localparam int PROD_W = NSQ_W + SUM_W;
	localparam int PAB_W  = 3 * AXIS_BITS;
	localparam int INIT_W = 3 * AXIS_BITS + 2;
	localparam int STEP_W = 3 * AXIS_BITS + 4;
	localparam int PW     = mer_pkg::POINT_W;
	localparam logic signed [CUR_W-1:0] CUR_ONE = CUR_W'(1);

	logic signed [mer_pkg::CENTER_W-1:0] center_x_q, center_y_q;
	logic [AXIS_BITS-1:0]                semi_a_q, semi_b_q;
	logic [SQ_W-1:0]                     a2_q, b2_q;
	logic [SUM_W-1:0]                    s_q;
	logic [LIM_W-1:0]                    lim1_q, lim2_q;
	logic [PAB_W-1:0]                    pab_q, pba_q;
	logic signed [DEC_W-1:0]             decision_q, dec_r2_q;
	logic signed [CUR_W-1:0]             cur_x_q, cur_y_q;
	mer_pkg::phase_t                     phase_q;
	logic [NSQ_W-1:0]                    sq_q;
	logic [PROD_W-1:0]                   prod_q;
	logic signed [STEP_W-1:0]            plin_q, pdec_q;
	logic                                pix_valid_q;
	logic signed [PW-1:0]                pix_x_q, pix_y_q;
	logic                                last_q, done_q;

	logic                    ph_r1;
	logic signed [CUR_W-1:0] n_main, n_other;
	logic [CUR_W-1:0]        mag;
	logic [LIM_W-1:0]        lim_sel;
	logic                    in_region;
	logic [SQ_W-1:0]         coef_lin, coef_dec;
	logic signed [CUR_W+1:0] lin_fac;
	logic signed [CUR_W:0]   dec_fac;
	logic signed [STEP_W-1:0] plin_d, pdec_d;
	logic signed [INIT_W-1:0] init_r1, init_r2;
	logic                    nonneg;
	logic signed [DEC_W-1:0] dec_next;
	logic signed [PW-1:0]    cx_p, cy_p, cen_x, cen_y, pix_x_d, pix_y_d;
	logic                    out_free;

	// region 1 walks x and steps y down, region 2 the mirror image
	assign ph_r1    = (phase_q == mer_pkg::PH_R1);
	assign n_main   = ph_r1 ? cur_x_q : cur_y_q;
	assign n_other  = ph_r1 ? cur_y_q : cur_x_q;
	assign coef_lin = ph_r1 ? b2_q : a2_q;
	assign coef_dec = ph_r1 ? a2_q : b2_q;
	assign lim_sel  = ph_r1 ? lim1_q : lim2_q;
	assign mag      = n_main[CUR_W-1] ? $unsigned(-n_main) : $unsigned(n_main);

	// n*n*(a2+b2) <= lim, lim being a2*a2 in region 1 and b2*b2 in region 2, exact
	assign in_region = prod_q <= PROD_W'(lim_sel);

	assign lin_fac = (CUR_W+2)'(n_main) + (CUR_W+2)'(n_main) + (CUR_W+2)'(3);
	assign dec_fac = (CUR_W+1)'(n_other) - (CUR_W+1)'(1);
	assign plin_d  = STEP_W'(lin_fac) * $signed(STEP_W'(coef_lin));
	assign pdec_d  = (STEP_W'(dec_fac) * $signed(STEP_W'(coef_dec))) <<< 1;

	assign init_r1 = $signed(INIT_W'(b2_q)) - $signed(INIT_W'(pab_q))
		+ $signed(INIT_W'(a2_q >> 2));
	assign init_r2 = $signed(INIT_W'(a2_q)) - $signed(INIT_W'(pba_q))
		+ $signed(INIT_W'(b2_q >> 2));

	assign nonneg   = !decision_q[DEC_W-1];
	assign dec_next = decision_q + DEC_W'(plin_q) - (nonneg ? DEC_W'(pdec_q) : '0);

	// pixel coordinates wrap to the output width
	assign cx_p    = PW'(cur_x_q);
	assign cy_p    = PW'(cur_y_q);
	assign cen_x   = PW'(center_x_q);
	assign cen_y   = PW'(center_y_q);
	assign pix_x_d = ctl.pix_idx[0] ? cen_x - cx_p : cen_x + cx_p;
	assign pix_y_d = ctl.pix_idx[1] ? cen_y - cy_p : cen_y + cy_p;

	assign out_free = !pix_valid_q || pix_ready;

	always_ff @(posedge clk) begin
		case (ctl.op)
			mer_pkg::OP_LATCH: begin
				center_x_q <= center_x;
				center_y_q <= center_y;
				semi_a_q   <= AXIS_BITS'(semi_a);
				semi_b_q   <= AXIS_BITS'(semi_b);
			end
			mer_pkg::OP_SQ_AB: begin
				a2_q <= SQ_W'(semi_a_q) * SQ_W'(semi_a_q);
				b2_q <= SQ_W'(semi_b_q) * SQ_W'(semi_b_q);
			end
			mer_pkg::OP_INIT_MUL: begin
				s_q    <= SUM_W'(a2_q) + SUM_W'(b2_q);
				lim1_q <= LIM_W'(a2_q) * LIM_W'(a2_q);
				lim2_q <= LIM_W'(b2_q) * LIM_W'(b2_q);
				pab_q  <= PAB_W'(a2_q) * PAB_W'(semi_b_q);
				pba_q  <= PAB_W'(b2_q) * PAB_W'(semi_a_q);
			end
			mer_pkg::OP_INIT_SET: begin
				decision_q <= DEC_W'(init_r1);
				dec_r2_q   <= DEC_W'(init_r2);
				cur_x_q    <= '0;
				cur_y_q    <= $signed(CUR_W'(semi_b_q));
			end
			mer_pkg::OP_CHK_SQ: begin
				sq_q <= NSQ_W'(mag) * NSQ_W'(mag);
			end
			mer_pkg::OP_CHK_MUL: begin
				prod_q <= PROD_W'(sq_q) * PROD_W'(s_q);
			end
			mer_pkg::OP_CHK_EVAL: begin
				if (!in_region && ph_r1) begin
					cur_x_q    <= $signed(CUR_W'(semi_a_q));
					cur_y_q    <= '0;
					decision_q <= dec_r2_q;
				end
			end
			mer_pkg::OP_STEP_MUL: begin
				plin_q <= plin_d;
				pdec_q <= pdec_d;
			end
			mer_pkg::OP_EMIT: begin
				pix_x_q <= pix_x_d;
				pix_y_q <= pix_y_d;
				last_q  <= (ctl.pix_idx == mer_pkg::LAST_PIX);
				done_q  <= 1'b0;
				// advance once the fourth mirror image has been taken
				if (ctl.pix_idx == mer_pkg::LAST_PIX) begin
					decision_q <= dec_next;
					if (ph_r1) begin
						cur_x_q <= cur_x_q + CUR_ONE;
						if (nonneg) begin
							cur_y_q <= cur_y_q - CUR_ONE;
						end
					end else begin
						cur_y_q <= cur_y_q + CUR_ONE;
						if (nonneg) begin
							cur_x_q <= cur_x_q - CUR_ONE;
						end
					end
				end
			end
			mer_pkg::OP_EMIT_DONE: begin
				pix_x_q <= '0;
				pix_y_q <= '0;
				last_q  <= 1'b1;
				done_q  <= 1'b1;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= mer_pkg::PH_DONE;
			pix_valid_q <= 1'b0;
		end else begin
			if (ctl.op == mer_pkg::OP_INIT_SET) begin
				phase_q <= mer_pkg::PH_R1;
			end else if (ctl.op == mer_pkg::OP_CHK_EVAL && !in_region) begin
				phase_q <= ph_r1 ? mer_pkg::PH_R2 : mer_pkg::PH_DONE;
			end
			if (ctl.op == mer_pkg::OP_EMIT || ctl.op == mer_pkg::OP_EMIT_DONE) begin
				pix_valid_q <= 1'b1;
			end else if (pix_ready) begin
				pix_valid_q <= 1'b0;
			end
		end
	end

	assign sts.phase     = phase_q;
	assign sts.in_region = in_region;
	assign sts.out_free  = out_free;

	assign pix_valid = pix_valid_q;
	assign point_x   = pix_x_q;
	assign point_y   = pix_y_q;
	assign last      = last_q;
	assign done_res  = done_q;

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(pix_valid_q && !pix_ready) |->
		(ctl.op != mer_pkg::OP_EMIT && ctl.op != mer_pkg::OP_EMIT_DONE))
		else $error("output word overwritten while waiting");

	a_done_word: assert property (@(posedge clk) disable iff (!arst_n)
		(pix_valid_q && done_q) |-> (last_q && pix_x_q == '0 && pix_y_q == '0))
		else $error("done word carries a pixel or lacks last");

	a_r1_exit: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == mer_pkg::PH_R1) |=>
		(phase_q == mer_pkg::PH_R1 || phase_q == mer_pkg::PH_R2))
		else $error("region 1 left for a phase other than region 2");

endmodule

// ===== design/midpoint_ellipse_rasterizer.sv =====
`timescale 1ns / 1ps
// Start word: setup multiplies (SQ_AB, INIT_MUL, INIT_SET), then the next word is taken.
// Step word: region check (CHK_SQ, CHK_MUL, CHK_EVAL), step multiply (STEP_MUL), then
//   4 pixel words at one per cycle while pix does not stall; region check again when
//   region 1 hands over to region 2. Stalls on pix hold back every output word.
// Done word: loaded in DONE_OUT, after a region check when a step ends region 2.
// Reset (arst_n low, asynchronous): sequencer idle, no ellipse active, output register empty.
module midpoint_ellipse_rasterizer #(
	parameter int AXIS_BITS = mer_pkg::AXIS_BITS_DEF
) (
	input logic       clk,
	input logic       arst_n,
	mer_cmd_if.sink   cmd,
	mer_pix_if.source pix
);

	// Command and status between the sequencer and the datapath.
	mer_pkg::dp_cmd_t dp_cmd;
	mer_pkg::dp_sts_t dp_sts;

	// Sequencer: accepts a word only when idle, then walks the datapath through
	// setup (start) or region check, step multiply and four pixel loads (step),
	// or the done word. The fourth pixel goes into the output register and the
	// sequencer returns to idle at once, so the next word is taken while it waits.
	mer_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (cmd.valid),
		.req_kind  (cmd.kind),
		.req_ready (cmd.ready),
		.sts       (dp_sts),
		.cmd       (dp_cmd)
	);

	// Datapath: holds the latched operands, the squared axes and the exact region
	// limits, the current point and decision term, and the output word register.
	// Region bound n*n*(a2+b2) <= a2*a2 (b2*b2 in region 2) is checked without any division.
	mer_dp #(
		.AXIS_BITS (AXIS_BITS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (dp_cmd),
		.sts       (dp_sts),
		.center_x  (cmd.center_x),
		.center_y  (cmd.center_y),
		.semi_a    (cmd.semi_a),
		.semi_b    (cmd.semi_b),
		.pix_valid (pix.valid),
		.pix_ready (pix.ready),
		.point_x   (pix.point_x),
		.point_y   (pix.point_y),
		.last      (pix.last),
		.done_res  (pix.done_res)
	);

endmodule
